// ===== hdl/hhdd_pkg.sv =====
// shared types, codes and constants for the heading hold differential drive block
package hhdd_pkg;

    // heading in whole degrees
    typedef logic signed [8:0]  t_heading;
    // Q8.8 gain
    typedef logic signed [15:0] t_gain;
    // clamp on the error sum
    typedef logic        [14:0] t_limit;
    // unsigned speed or pwm magnitude
    typedef logic        [7:0]  t_speed;
    // accumulated heading error
    typedef logic signed [15:0] t_esum;
    // error difference between ticks
    typedef logic signed [9:0]  t_delta;
    // motor speed before saturation
    typedef logic signed [26:0] t_raw_speed;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_MIN_SPEED      = 3'd4,
        CFG_BASE_SPEED     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_speed pwm;
        t_dir   dir;
    } t_motor_cmd;

    localparam t_speed     MIN_SPEED_RESET  = 8'd10;
    localparam t_speed     BASE_SPEED_RESET = 8'd200;
    localparam t_raw_speed SPEED_FULL       = 27'sd255;

endpackage

// ===== hdl/hhdd_if.sv =====
// handshake channels: control tick in, motor word out, register writes
interface hhdd_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    hhdd_pkg::t_heading heading;
    hhdd_pkg::t_heading target_heading;
    logic [3:0]         line_flags;

    modport source(output valid, op, heading, target_heading, line_flags, input ready);
    modport sink(input valid, op, heading, target_heading, line_flags, output ready);
endinterface

interface hhdd_out_if;
    logic               valid;
    logic               ready;
    hhdd_pkg::t_speed   left_pwm;
    hhdd_pkg::t_dir     left_dir;
    hhdd_pkg::t_speed   right_pwm;
    hhdd_pkg::t_dir     right_dir;
    logic               line_escape;
    hhdd_pkg::t_heading heading_error;

    modport source(output valid, left_pwm, left_dir, right_pwm, right_dir, line_escape,
                   heading_error, input ready);
    modport sink(input valid, left_pwm, left_dir, right_pwm, right_dir, line_escape,
                 heading_error, output ready);
endinterface

interface hhdd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/heading_hold_differential_drive.sv =====
// top level: pid heading hold with line escape for a two-motor drive
//
//  channel  | modport | word                                   | accepted when
//  ---------+---------+----------------------------------------+----------------------
//  i_in     | sink    | op, heading, target_heading, line_flags | valid & ready
//  o_out    | source  | pwm/dir per motor, escape, error        | valid & ready
//  i_cfg    | sink    | index, data (six registers)             | valid (ready held high)
//
//  four register stages: input, error/integral, products, result
//  one word in per cycle unless o_out stalls; a word passes error/integral and products into the result register
//  integral and previous error are updated as a non-escape word leaves the input stage, in order
//  each stage fills while empty even if the result register is stalled
//  synchronous active-low reset empties the pipe and loads register defaults
module heading_hold_differential_drive (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hhdd_in_if.sink    i_in,
    hhdd_out_if.source o_out,
    hhdd_cfg_if.sink   i_cfg
);
    import hhdd_pkg::*;

    // configuration registers
    t_gain  r_prop_gain;
    t_gain  r_integ_gain;
    t_gain  r_deriv_gain;
    t_limit r_integral_limit;
    t_speed r_min_speed;
    t_speed r_base_speed;

    // controller state
    t_heading r_prev_err;
    t_esum    r_esum;

    // stage valids
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;

    // stage 1: accepted word
    logic       r_s1_op;
    t_heading   r_s1_head;
    t_heading   r_s1_tgt;
    logic [3:0] r_s1_flags;

    // stage 2: wrapped error, new integral, difference
    logic     r_s2_op, r_s2_esc, r_s2_fwd;
    t_heading r_s2_err;
    t_esum    r_s2_esum;
    t_delta   r_s2_d;

    // stage 3: gain products
    logic               r_s3_op, r_s3_esc, r_s3_fwd;
    t_heading           r_s3_err;
    logic signed [24:0] r_s3_pp;
    logic signed [31:0] r_s3_pi;
    logic signed [25:0] r_s3_pd;

    // result register
    t_motor_cmd r_out_left, r_out_right;
    logic       r_out_esc;
    t_heading   r_out_err;

    // flow control, each stage moves when the next one is empty or moving
    logic free_out, go3, free3, go2, free2, go1, free1;

    assign free_out = ~r_out_v | o_out.ready;
    assign go3      = r_s3_v & free_out;
    assign free3    = ~r_s3_v | go3;
    assign go2      = r_s2_v & free3;
    assign free2    = ~r_s2_v | go2;
    assign go1      = r_s1_v & free2;
    assign free1    = ~r_s1_v | go1;

    assign i_in.ready  = free1;
    assign i_cfg.ready = 1'b1;

    // stage 1 logic: error wrap, integral clamp and error difference
    logic              s1_esc;
    logic signed [11:0] wrap_sum;
    logic        [10:0] wrap_u;
    logic        [8:0]  wrap_rem;
    logic signed [9:0]  err_w;
    t_heading           n_err;
    logic signed [16:0] acc;
    logic signed [16:0] lim;
    t_esum              n_esum;
    t_delta             n_d;

    always_comb begin
        s1_esc   = |r_s1_flags;
        // heading + 540 - target is always positive and below three periods
        wrap_sum = 12'sd540 + 12'(r_s1_head) - 12'(r_s1_tgt);
        wrap_u   = wrap_sum[10:0];
        if (wrap_u >= 11'd720) begin
            wrap_rem = 9'(wrap_u - 11'd720);
        end else if (wrap_u >= 11'd360) begin
            wrap_rem = 9'(wrap_u - 11'd360);
        end else begin
            wrap_rem = wrap_u[8:0];
        end
        err_w = $signed({1'b0, wrap_rem}) - 10'sd180;
        n_err = err_w[8:0];

        // accumulate and clamp symmetrically
        acc = 17'(r_esum) + 17'(n_err);
        lim = $signed({2'b00, r_integral_limit});
        if (acc > lim) begin
            n_esum = lim[15:0];
        end else if (acc < -lim) begin
            n_esum = 16'(-lim);
        end else begin
            n_esum = acc[15:0];
        end

        n_d = 10'(n_err) - 10'(r_prev_err);
    end

    // stage 3 logic: sum, truncating shift, motor mix
    logic signed [33:0] pid_sum;
    logic signed [33:0] pid_biased;
    logic signed [25:0] pid_u;
    t_raw_speed         base_w;
    t_raw_speed         n_left, n_right;
    t_motor_cmd         left_cmd, right_cmd;

    always_comb begin
        pid_sum    = 34'(r_s3_pp) + 34'(r_s3_pi) + 34'(r_s3_pd);
        // divide by 256 rounding toward zero
        pid_biased = pid_sum[33] ? pid_sum + 34'sd255 : pid_sum;
        pid_u      = pid_biased[33:8];
        base_w     = $signed({19'd0, r_base_speed});

        if (r_s3_esc) begin
            n_left  = r_s3_fwd ? SPEED_FULL : -SPEED_FULL;
            n_right = n_left;
        end else if (r_s3_op) begin
            n_left  = base_w + 27'(pid_u);
            n_right = base_w - 27'(pid_u);
        end else begin
            n_left  = 27'(pid_u);
            n_right = -27'(pid_u);
        end
    end

    hhdd_motor_map u_left_map (
        .i_speed     (n_left),
        .i_min_speed (r_min_speed),
        .o_cmd       (left_cmd)
    );

    hhdd_motor_map u_right_map (
        .i_speed     (n_right),
        .i_min_speed (r_min_speed),
        .o_cmd       (right_cmd)
    );

    // control state and registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain      <= '0;
            r_integ_gain     <= '0;
            r_deriv_gain     <= '0;
            r_integral_limit <= '0;
            r_min_speed      <= MIN_SPEED_RESET;
            r_base_speed     <= BASE_SPEED_RESET;
            r_prev_err       <= '0;
            r_esum           <= '0;
            r_s1_v           <= 1'b0;
            r_s2_v           <= 1'b0;
            r_s3_v           <= 1'b0;
            r_out_v          <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_PROP_GAIN:      r_prop_gain      <= i_cfg.data;
                    CFG_INTEG_GAIN:     r_integ_gain     <= i_cfg.data;
                    CFG_DERIV_GAIN:     r_deriv_gain     <= i_cfg.data;
                    CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg.data[14:0];
                    CFG_MIN_SPEED:      r_min_speed      <= i_cfg.data[7:0];
                    CFG_BASE_SPEED:     r_base_speed     <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
            // pid state moves only with a non-escape word
            if (go1 && !s1_esc) begin
                r_prev_err <= n_err;
                r_esum     <= n_esum;
            end
            if (free1) begin
                r_s1_v <= i_in.valid;
            end
            if (free2) begin
                r_s2_v <= r_s1_v;
            end
            if (free3) begin
                r_s3_v <= r_s2_v;
            end
            if (free_out) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1_op    <= i_in.op;
            r_s1_head  <= i_in.heading;
            r_s1_tgt   <= i_in.target_heading;
            r_s1_flags <= i_in.line_flags;
        end
        if (free2) begin
            r_s2_op   <= r_s1_op;
            r_s2_esc  <= s1_esc;
            r_s2_fwd  <= |r_s1_flags[1:0];
            r_s2_err  <= s1_esc ? '0 : n_err;
            r_s2_esum <= n_esum;
            r_s2_d    <= n_d;
        end
        if (free3) begin
            r_s3_op  <= r_s2_op;
            r_s3_esc <= r_s2_esc;
            r_s3_fwd <= r_s2_fwd;
            r_s3_err <= r_s2_err;
            r_s3_pp  <= 25'(r_prop_gain) * 25'(r_s2_err);
            r_s3_pi  <= 32'(r_integ_gain) * 32'(r_s2_esum);
            r_s3_pd  <= 26'(r_deriv_gain) * 26'(r_s2_d);
        end
        if (free_out) begin
            r_out_left  <= left_cmd;
            r_out_right <= right_cmd;
            r_out_esc   <= r_s3_esc;
            r_out_err   <= r_s3_err;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.left_pwm      = r_out_left.pwm;
    assign o_out.left_dir      = r_out_left.dir;
    assign o_out.right_pwm     = r_out_right.pwm;
    assign o_out.right_dir     = r_out_right.dir;
    assign o_out.line_escape   = r_out_esc;
    assign o_out.heading_error = r_out_err;

endmodule

// ===== hdl/hhdd_motor_map.sv =====
// saturates one motor speed and maps it to direction and pwm magnitude
module hhdd_motor_map (
    input  hhdd_pkg::t_raw_speed i_speed,
    input  hhdd_pkg::t_speed     i_min_speed,
    output hhdd_pkg::t_motor_cmd o_cmd
);
    import hhdd_pkg::*;

    logic signed [9:0] sat;
    logic        [9:0] mag;

    always_comb begin
        // clamp to -255..255
        if (i_speed > SPEED_FULL) begin
            sat = 10'sd255;
        end else if (i_speed < -SPEED_FULL) begin
            sat = -10'sd255;
        end else begin
            sat = i_speed[9:0];
        end
        mag = sat[9] ? 10'(-sat) : 10'(sat);

        if (mag < {2'b00, i_min_speed}) begin
            o_cmd.dir = DIR_STOP;
            o_cmd.pwm = '0;
        end else if (!sat[9]) begin
            o_cmd.dir = DIR_FWD;
            o_cmd.pwm = mag[7:0];
        end else begin
            o_cmd.dir = DIR_REV;
            o_cmd.pwm = mag[7:0];
        end
    end
endmodule
